>>> hdl/cwc_pkg.sv
// Shared types and constants for the congestion window control block.
package cwc_pkg;

  localparam int DATA_W = 32;
  localparam int SEG_W  = 16;
  localparam int DIV_CNT_W = $clog2(DATA_W);

  localparam logic [SEG_W-1:0]  RESET_SEGMENT  = SEG_W'(1460);
  localparam logic [DATA_W-1:0] OPEN_THRESHOLD = DATA_W'(65535);
  localparam logic [1:0]        DUP_TRIGGER    = 2'd3;

  // Event kinds carried in func
  typedef enum logic [1:0] {
    FUNC_OPEN    = 2'd0,
    FUNC_NEW_ACK = 2'd1,
    FUNC_DUP_ACK = 2'd2,
    FUNC_TIMEOUT = 2'd3
  } func_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } state_t;

endpackage

>>> hdl/cwc_div.sv
// Iterative restoring divider: one quotient bit per clock.
module cwc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cwc_pkg::DATA_W-1:0] dividend,
  input  logic [cwc_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [cwc_pkg::DATA_W-1:0] quotient
);
  import cwc_pkg::*;

  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    quo;
  logic [DATA_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      diff;
  logic                 fits;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem, quo[DATA_W-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

>>> hdl/congestion_window_control_core.sv
// Congestion window control core (Reno style). One event per input transaction, one result
// per event. Open, duplicate ACK, timeout, slow-start ACK and zero-window avoidance ACK
// events go from accept through the done state to the output register; a congestion-avoidance
// ACK with a nonzero window first runs the bit-serial divider, which forms segment^2/window
// one quotient bit per clock over 32 steps. The done state holds while the output is full.
// The input is not ready while an event is in progress; one finished result may wait in the
// output register while the next event is taken. segment_size writes apply from the next event.
module congestion_window_control_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [cwc_pkg::SEG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  func,
  input  logic                        has_outstanding,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cwc_pkg::DATA_W-1:0]  window,
  output logic [cwc_pkg::DATA_W-1:0]  threshold,
  output logic                        slow_start,
  output logic                        loss_detected,
  output logic                        retransmit_request
);
  import cwc_pkg::*;

  state_t state, state_next;

  logic [SEG_W-1:0]  segment_size;
  logic [DATA_W-1:0] cwnd;
  logic [DATA_W-1:0] ssthresh;
  logic [1:0]        dup_count;
  logic              loss;
  logic              outstanding;
  logic [DATA_W-1:0] seg_sq;

  logic              accept;
  logic              out_free;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;

  logic [DATA_W-1:0] half;
  logic [DATA_W-1:0] floor2;
  logic [DATA_W-1:0] loss_thr;
  logic [DATA_W:0]   add_sum;
  logic [DATA_W-1:0] add_sat;
  logic [DATA_W-1:0] add_operand;
  logic [1:0]        dup_inc;
  logic              need_div;
  func_t             fn;

  assign fn       = func_t'(func);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Loss threshold: max(window/2, 2*segment)
  always_comb begin
    half     = {1'b0, cwnd[DATA_W-1:1]};
    floor2   = DATA_W'({segment_size, 1'b0});
    loss_thr = (half < floor2) ? floor2 : half;
  end

  // Shared saturating adder: segment step at accept, divider quotient afterwards
  always_comb begin
    add_operand = (state == S_DIV_WAIT) ? div_quo : DATA_W'(segment_size);
    add_sum     = {1'b0, cwnd} + {1'b0, add_operand};
    add_sat     = add_sum[DATA_W] ? '1 : add_sum[DATA_W-1:0];
  end

  assign dup_inc  = dup_count + 2'd1;
  // Avoidance needs the divide unless the window is zero (increment taken as 0)
  assign need_div = (fn == FUNC_NEW_ACK) && !(cwnd < ssthresh) && (cwnd != '0);

  // Next state and sequencer outputs
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = need_div ? S_DIV_START : S_DONE;
        end
      end
      S_DIV_START: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_size <= RESET_SEGMENT;
    end else if (cfg_write) begin
      segment_size <= cfg_data;
    end
  end

  // Connection state update
  always_ff @(posedge clk) begin
    if (rst) begin
      cwnd      <= DATA_W'(RESET_SEGMENT);
      ssthresh  <= OPEN_THRESHOLD;
      dup_count <= '0;
    end else if (accept) begin
      case (fn)
        FUNC_OPEN: begin
          cwnd      <= DATA_W'(segment_size);
          ssthresh  <= OPEN_THRESHOLD;
          dup_count <= '0;
        end
        FUNC_NEW_ACK: begin
          if (cwnd < ssthresh) begin
            cwnd <= add_sat;
          end
          dup_count <= '0;
        end
        FUNC_DUP_ACK: begin
          if (dup_inc == DUP_TRIGGER) begin
            ssthresh  <= loss_thr;
            cwnd      <= loss_thr;
            dup_count <= '0;
          end else begin
            dup_count <= dup_inc;
          end
        end
        FUNC_TIMEOUT: begin
          ssthresh  <= loss_thr;
          cwnd      <= DATA_W'(segment_size);
          dup_count <= '0;
        end
        default: dup_count <= '0;
      endcase
    end else if (state == S_DIV_WAIT && div_done) begin
      cwnd <= add_sat;
    end
  end

  // Per-transaction flags and divider operand
  always_ff @(posedge clk) begin
    if (accept) begin
      loss        <= (fn == FUNC_TIMEOUT) ||
                     ((fn == FUNC_DUP_ACK) && (dup_inc == DUP_TRIGGER));
      outstanding <= has_outstanding;
      seg_sq      <= DATA_W'(segment_size) * DATA_W'(segment_size);
    end
  end

  cwc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (seg_sq),
    .divisor  (cwnd),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      window             <= cwnd;
      threshold          <= ssthresh;
      slow_start         <= (cwnd < ssthresh);
      loss_detected      <= loss;
      retransmit_request <= loss && outstanding;
    end
  end

endmodule

>>> test/tb_congestion_window_control_core.sv
// Self-checking testbench for the Reno-style congestion window control core.
`timescale 1ns / 1ps

module tb_congestion_window_control_core;
  import cwc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned DIR_ROWS     = 28;

  // One window update as seen on the result port
  typedef struct packed {
    logic [DATA_W-1:0] window;
    logic [DATA_W-1:0] threshold;
    logic              slow_start;
    logic              loss_detected;
    logic              retransmit_request;
  } cwnd_update_t;

  // Directed row: either a segment size write or one event, with an optional typed result
  typedef struct packed {
    logic              seg_write;
    logic [SEG_W-1:0]  seg_value;
    func_t             ev;
    logic              outstanding;
    logic              typed;
    cwnd_update_t      res;
  } dir_row_t;

  localparam cwnd_update_t NO_RES = '0;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write;
  logic [SEG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_ready;
  func_t             ev_func;
  logic              has_outstanding;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] window;
  logic [DATA_W-1:0] threshold;
  logic              slow_start;
  logic              loss_detected;
  logic              retransmit_request;

  // Shadow of the block's congestion state and segment size register
  logic [SEG_W-1:0]  seg_size;
  logic [DATA_W-1:0] cwnd;
  logic [DATA_W-1:0] ssthresh;
  logic [1:0]        dup_cnt;

  cwnd_update_t      expected_updates[$];
  int unsigned       mismatch_cnt = 0;
  int unsigned       cycle_cnt = 0;
  int unsigned       stall_left = 0;
  bit                idle_on = 1'b0;

  // Directed stimulus: slow start, fast retransmit, avoidance, timeout, open,
  // broken dup runs, largest and smallest segment, zero segment and zero window
  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{1'b0, 16'd0, FUNC_NEW_ACK, 1'b0, 1'b1, '{32'd2920, 32'd65535, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 16'd0, FUNC_DUP_ACK, 1'b1, 1'b1, '{32'd2920, 32'd65535, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 16'd0, FUNC_DUP_ACK, 1'b0, 1'b1, '{32'd2920, 32'd65535, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 16'd0, FUNC_DUP_ACK, 1'b1, 1'b1, '{32'd2920, 32'd2920, 1'b0, 1'b1, 1'b1}},
    '{1'b0, 16'd0, FUNC_NEW_ACK, 1'b1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_TIMEOUT, 1'b0, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_OPEN,    1'b1, 1'b1, '{32'd1460, 32'd65535, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 16'd0, FUNC_DUP_ACK, 1'b0, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_NEW_ACK, 1'b0, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_DUP_ACK, 1'b1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_DUP_ACK, 1'b1, 1'b0, NO_RES},
    '{1'b1, 16'd65535, FUNC_OPEN, 1'b0, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_OPEN,    1'b0, 1'b1, '{32'd65535, 32'd65535, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 16'd0, FUNC_NEW_ACK, 1'b1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_TIMEOUT, 1'b1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_NEW_ACK, 1'b0, 1'b0, NO_RES},
    '{1'b1, 16'd1, FUNC_OPEN, 1'b0, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_OPEN,    1'b1, 1'b1, '{32'd1, 32'd65535, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 16'd0, FUNC_TIMEOUT, 1'b1, 1'b1, '{32'd1, 32'd2, 1'b1, 1'b1, 1'b1}},
    '{1'b1, 16'd0, FUNC_OPEN, 1'b0, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_OPEN,    1'b0, 1'b1, '{32'd0, 32'd65535, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 16'd0, FUNC_NEW_ACK, 1'b1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_TIMEOUT, 1'b0, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b1, 1'b0}},
    '{1'b0, 16'd0, FUNC_NEW_ACK, 1'b0, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 16'd0, FUNC_DUP_ACK, 1'b1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_DUP_ACK, 1'b1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_DUP_ACK, 1'b1, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b1, 1'b1}},
    '{1'b1, 16'd1460, FUNC_OPEN, 1'b0, 1'b0, NO_RES}
  };

  congestion_window_control_core dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .func               (ev_func),
    .has_outstanding    (has_outstanding),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .window             (window),
    .threshold          (threshold),
    .slow_start         (slow_start),
    .loss_detected      (loss_detected),
    .retransmit_request (retransmit_request)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Threshold after a loss: half the window, never below two segments
  function automatic logic [DATA_W-1:0] loss_floor();
    logic [DATA_W-1:0] half;
    logic [DATA_W-1:0] two_seg;
    half    = cwnd >> 1;
    two_seg = DATA_W'(seg_size) << 1;
    return (half < two_seg) ? two_seg : half;
  endfunction

  // Advance the shadow state by one event and return the resulting update
  function automatic cwnd_update_t reno_step(input func_t ev, input logic outstanding);
    cwnd_update_t      upd;
    logic [63:0]       growth;
    logic [DATA_W:0]   sum;
    logic              loss;
    loss = 1'b0;
    case (ev)
      FUNC_OPEN: begin
        cwnd     = DATA_W'(seg_size);
        ssthresh = OPEN_THRESHOLD;
        dup_cnt  = '0;
      end
      FUNC_NEW_ACK: begin
        // slow start adds a segment; avoidance adds seg^2/window, zero if window is zero
        if (cwnd < ssthresh)
          growth = 64'(seg_size);
        else if (cwnd == '0)
          growth = '0;
        else
          growth = (64'(seg_size) * 64'(seg_size)) / 64'(cwnd);
        sum     = {1'b0, cwnd} + growth[DATA_W:0];
        cwnd    = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
        dup_cnt = '0;
      end
      FUNC_DUP_ACK: begin
        dup_cnt = dup_cnt + 2'd1;
        if (dup_cnt >= DUP_TRIGGER) begin
          ssthresh = loss_floor();
          cwnd     = ssthresh;
          dup_cnt  = '0;
          loss     = 1'b1;
        end
      end
      default: begin
        ssthresh = loss_floor();
        cwnd     = DATA_W'(seg_size);
        dup_cnt  = '0;
        loss     = 1'b1;
      end
    endcase
    upd.window             = cwnd;
    upd.threshold          = ssthresh;
    upd.slow_start         = cwnd < ssthresh;
    upd.loss_detected      = loss;
    upd.retransmit_request = loss & outstanding;
    return upd;
  endfunction

  // Present one event and hold it until the transaction completes
  task automatic send_event(input func_t ev, input logic outstanding, input logic typed,
                            input cwnd_update_t typed_res);
    cwnd_update_t upd;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    ev_func         <= ev;
    has_outstanding <= outstanding;
    do @(posedge clk); while (!in_ready);
    upd = reno_step(ev, outstanding);
    expected_updates.push_back(typed ? typed_res : upd);
    @(negedge clk);
  endtask

  // Let every pending result drain, then write the segment size while idle
  task automatic write_segment(input logic [SEG_W-1:0] value);
    in_valid <= 1'b0;
    while (expected_updates.size() != 0) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    seg_size = value;
  endtask

  // Mostly well-formed Reno sequences with random content, some random noise
  task automatic drive_traffic(input int unsigned n_events);
    int unsigned sent;
    int unsigned pick;
    int unsigned run;
    sent = 0;
    while (sent < n_events) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // ACK run; the long ones carry slow start over into avoidance
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        repeat (run) send_event(FUNC_NEW_ACK, 1'($urandom_range(0, 1)), 1'b0, NO_RES);
      end else if (pick < 65) begin
        run = 3;
        repeat (run) send_event(FUNC_DUP_ACK, 1'($urandom_range(0, 1)), 1'b0, NO_RES);
      end else if (pick < 75) begin
        // dup run broken by a new ACK before the trigger
        run = $urandom_range(1, 2) + 1;
        repeat (run - 1) send_event(FUNC_DUP_ACK, 1'($urandom_range(0, 1)), 1'b0, NO_RES);
        send_event(FUNC_NEW_ACK, 1'($urandom_range(0, 1)), 1'b0, NO_RES);
      end else if (pick < 83) begin
        run = 1;
        send_event(FUNC_TIMEOUT, 1'($urandom_range(0, 1)), 1'b0, NO_RES);
      end else if (pick < 88) begin
        run = 1;
        send_event(FUNC_OPEN, 1'($urandom_range(0, 1)), 1'b0, NO_RES);
      end else begin
        run = $urandom_range(1, 4);
        repeat (run) send_event(func_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                1'b0, NO_RES);
      end
      sent += run;
    end
  endtask

  // Result side back-pressure in bursts
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expected update
  always @(posedge clk) begin
    cwnd_update_t exp_upd;
    if (!rst && out_valid && out_ready) begin
      if (expected_updates.size() == 0) begin
        $error("unexpected result: window %0d threshold %0d", window, threshold);
        mismatch_cnt++;
      end else begin
        exp_upd = expected_updates.pop_front();
        if (window !== exp_upd.window) begin
          $error("window: expected %0d, got %0d", exp_upd.window, window);
          mismatch_cnt++;
        end
        if (threshold !== exp_upd.threshold) begin
          $error("threshold: expected %0d, got %0d", exp_upd.threshold, threshold);
          mismatch_cnt++;
        end
        if (slow_start !== exp_upd.slow_start) begin
          $error("slow_start: expected %0b, got %0b", exp_upd.slow_start, slow_start);
          mismatch_cnt++;
        end
        if (loss_detected !== exp_upd.loss_detected) begin
          $error("loss_detected: expected %0b, got %0b", exp_upd.loss_detected,
                 loss_detected);
          mismatch_cnt++;
        end
        if (retransmit_request !== exp_upd.retransmit_request) begin
          $error("retransmit_request: expected %0b, got %0b",
                 exp_upd.retransmit_request, retransmit_request);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_congestion_window_control_core: FAIL");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    ev_func         = FUNC_OPEN;
    has_outstanding = 1'b0;
    seg_size        = RESET_SEGMENT;
    cwnd            = DATA_W'(RESET_SEGMENT);
    ssthresh        = OPEN_THRESHOLD;
    dup_cnt         = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].seg_write)
        write_segment(dir_tab[i].seg_value);
      else
        send_event(dir_tab[i].ev, dir_tab[i].outstanding, dir_tab[i].typed, dir_tab[i].res);
    end

    // Random phases over several segment sizes, extremes included
    idle_on = 1'b1;
    drive_traffic(150);
    write_segment(16'd1);
    drive_traffic(140);
    write_segment(16'd65535);
    drive_traffic(140);
    idle_on = 1'b0;
    write_segment(16'd536);
    drive_traffic(120);
    idle_on = 1'b1;
    write_segment(16'($urandom_range(0, 65535)));
    drive_traffic(140);
    write_segment(16'd0);
    drive_traffic(40);
    write_segment(16'($urandom_range(1, 65535)));
    drive_traffic(140);

    // Final stretch at full rate on both sides
    idle_on = 1'b0;
    write_segment(RESET_SEGMENT);
    drive_traffic(200);

    in_valid <= 1'b0;
    while (expected_updates.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0)
      $display("tb_congestion_window_control_core: PASS");
    else
      $display("tb_congestion_window_control_core: FAIL");
    $finish;
  end

endmodule
